/* src/sict_pkg.sv */
`default_nettype none

package sict_pkg;

  localparam int unsigned DEF_COORD_BITS = 32;
  localparam int unsigned DEF_FRAC_BITS  = 16;

  typedef enum logic [1:0] {
    OUT_CONTACT = 2'd0,
    OUT_NEVER   = 2'd1,
    OUT_ALWAYS  = 2'd2
  } outcome_e;

endpackage

`default_nettype wire

/* src/swept_interval_contact_times_unit.sv */
// channel   | ports                                           | handshake
// ----------+-------------------------------------------------+-------------------------
// request   | first_/second_ start_i, width_i, velocity_i      | start, taken when !busy
// result    | outcome_o, enter_time_o, leave_time_o           | done_o, one-cycle strobe
//
// one request per cycle; busy stays low, nothing ever waits
// the pipeline runs stage 1, stage 2, the divider stages and the output stage;
// the restoring divider resolves one quotient bit per pipeline stage
// reset clears the valid bits of every stage and the done strobe
// results leave on done_o at once; the receiver cannot hold them off
`default_nettype none

module swept_interval_contact_times_unit import sict_pkg::*; #(
  parameter int unsigned COORD_BITS = DEF_COORD_BITS,
  parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic signed [COORD_BITS-1:0] first_start_i,
  input  wire logic        [COORD_BITS-2:0] first_width_i,
  input  wire logic signed [COORD_BITS-1:0] first_velocity_i,
  input  wire logic signed [COORD_BITS-1:0] second_start_i,
  input  wire logic        [COORD_BITS-2:0] second_width_i,
  input  wire logic signed [COORD_BITS-1:0] second_velocity_i,
  output      logic                         done_o,
  output      outcome_e                     outcome_o,
  output      logic signed [COORD_BITS-1:0] enter_time_o,
  output      logic signed [COORD_BITS-1:0] leave_time_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned MW = CB + 1;       // gap magnitude
  localparam int unsigned DW = CB + 1;       // velocity magnitude
  localparam int unsigned NW = MW + FRAC_BITS; // quotient bits resolved

  typedef struct packed {
    logic [CB-1:0] rem;
    logic [CB-1:0] quo;
    logic          hi;   // a quotient bit above the kept window was set
  } lane_t;

  typedef struct packed {
    logic [MW-1:0] num_e;
    logic [MW-1:0] num_l;
    logic [DW-1:0] den;
    logic          neg_e;
    logic          neg_l;
    logic          vzero;
    logic          sep;
  } ctx_t;

  function automatic lane_t div_step(lane_t in, logic nbit, logic [DW-1:0] den);
    lane_t         res;
    logic [CB:0]   t;
    logic [CB:0]   diff;
    logic          ge;
    t        = {in.rem, nbit};
    diff     = t - den;
    ge       = (t >= den);
    res.rem  = ge ? diff[CB-1:0] : t[CB-1:0];
    res.quo  = {in.quo[CB-2:0], ge};
    res.hi   = in.hi | in.quo[CB-1];
    return res;
  endfunction

  function automatic logic [CB-1:0] finish(lane_t l, logic neg);
    logic [CB-1:0] res;
    if (neg) begin
      if (l.hi || (l.quo[CB-1] && (|l.quo[CB-2:0]))) begin
        res = {1'b1, {(CB-1){1'b0}}};
      end else begin
        res = ~l.quo + 1'b1;
      end
    end else begin
      if (l.hi || l.quo[CB-1]) begin
        res = {1'b0, {(CB-1){1'b1}}};
      end else begin
        res = l.quo;
      end
    end
    return res;
  endfunction

  assign busy = 1'b0;

  // stage 1: relative velocity and the two gaps
  logic                  s1_valid_q;
  logic signed [CB:0]    s1_vel_q;
  logic signed [CB+1:0]  s1_near_q;
  logic signed [CB+1:0]  s1_far_q;

  logic signed [CB+1:0]  a_x, b_x, aw_x, bw_x;
  assign a_x  = {{2{first_start_i[CB-1]}}, first_start_i};
  assign b_x  = {{2{second_start_i[CB-1]}}, second_start_i};
  assign aw_x = {3'b000, first_width_i};
  assign bw_x = {3'b000, second_width_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_vel_q  <= {first_velocity_i[CB-1], first_velocity_i}
               - {second_velocity_i[CB-1], second_velocity_i};
    s1_near_q <= b_x - a_x - aw_x;
    s1_far_q  <= b_x + bw_x - a_x;
  end

  // stage 2: magnitudes, ordering by the sign of the velocity
  logic          s2_valid_q;
  ctx_t          s2_ctx_q;
  logic [CB+1:0] near_abs, far_abs;
  logic [CB:0]   vel_abs;
  logic          vel_neg;

  assign vel_neg  = s1_vel_q[CB];
  assign vel_abs  = vel_neg ? (~s1_vel_q + 1'b1) : s1_vel_q;
  assign near_abs = s1_near_q[CB+1] ? (~s1_near_q + 1'b1) : s1_near_q;
  assign far_abs  = s1_far_q[CB+1] ? (~s1_far_q + 1'b1) : s1_far_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_ctx_q.num_e <= vel_neg ? far_abs[MW-1:0] : near_abs[MW-1:0];
    s2_ctx_q.num_l <= vel_neg ? near_abs[MW-1:0] : far_abs[MW-1:0];
    s2_ctx_q.neg_e <= (vel_neg ? s1_far_q[CB+1] : s1_near_q[CB+1]) ^ vel_neg;
    s2_ctx_q.neg_l <= (vel_neg ? s1_near_q[CB+1] : s1_far_q[CB+1]) ^ vel_neg;
    s2_ctx_q.den   <= vel_abs;
    s2_ctx_q.vzero <= (s1_vel_q == '0);
    // separated when a ends before b starts or a starts after b ends
    s2_ctx_q.sep   <= (!s1_near_q[CB+1] && (s1_near_q != '0)) || s1_far_q[CB+1];
  end

  // divider: stage k resolves numerator bit NW-1-k for both lanes
  logic  div_valid_q [NW];
  ctx_t  div_ctx_q   [NW];
  lane_t div_e_q     [NW];
  lane_t div_l_q     [NW];

  for (genvar k = 0; k < NW; k++) begin : g_div
    localparam int unsigned P = NW - 1 - k;
    logic  vin;
    ctx_t  cin;
    lane_t ein, lin;
    logic  bit_e, bit_l;

    if (k == 0) begin : g_first
      assign vin = s2_valid_q;
      assign cin = s2_ctx_q;
      assign ein = '0;
      assign lin = '0;
    end else begin : g_next
      assign vin = div_valid_q[k-1];
      assign cin = div_ctx_q[k-1];
      assign ein = div_e_q[k-1];
      assign lin = div_l_q[k-1];
    end

    if (P >= FRAC_BITS) begin : g_int
      assign bit_e = cin.num_e[P-FRAC_BITS];
      assign bit_l = cin.num_l[P-FRAC_BITS];
    end else begin : g_frac
      assign bit_e = 1'b0;
      assign bit_l = 1'b0;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_valid_q[k] <= 1'b0;
      end else begin
        div_valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      div_ctx_q[k] <= cin;
      div_e_q[k]   <= div_step(ein, bit_e, cin.den);
      div_l_q[k]   <= div_step(lin, bit_l, cin.den);
    end
  end

  // output stage: saturate, apply sign, register the result; zero velocity gives never or always
  logic                 done_q;
  outcome_e             outcome_q;
  logic signed [CB-1:0] enter_q, leave_q;
  ctx_t                 last_ctx;

  assign last_ctx = div_ctx_q[NW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_valid_q[NW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_ctx.vzero) begin
      outcome_q <= last_ctx.sep ? OUT_NEVER : OUT_ALWAYS;
      enter_q   <= '0;
      leave_q   <= '0;
    end else begin
      outcome_q <= OUT_CONTACT;
      enter_q   <= finish(div_e_q[NW-1], last_ctx.neg_e);
      leave_q   <= finish(div_l_q[NW-1], last_ctx.neg_l);
    end
  end

  assign done_o       = done_q;
  assign outcome_o    = outcome_q;
  assign enter_time_o = enter_q;
  assign leave_time_o = leave_q;

endmodule

`default_nettype wire

/* src/sict_checker.sv */
`default_nettype none

module sict_checker import sict_pkg::*; #(
  parameter int unsigned COORD_BITS = DEF_COORD_BITS,
  parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic signed [COORD_BITS-1:0] first_velocity_i,
  input wire logic signed [COORD_BITS-1:0] second_velocity_i,
  input wire logic                         done_o,
  input wire outcome_e                     outcome_o,
  input wire logic signed [COORD_BITS-1:0] enter_time_o,
  input wire logic signed [COORD_BITS-1:0] leave_time_o
);

  localparam int unsigned LAT = COORD_BITS + FRAC_BITS + 4;

  logic req;
  assign req = start && !busy;

  // every request gives exactly one result, and no result comes without a request
  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |-> ##LAT done_o)
    else $error("request gave no result");

  a_done_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req, LAT))
    else $error("result without request");

  // contact exactly when the velocities differ
  a_contact_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((outcome_o == OUT_CONTACT)
                == $past(first_velocity_i != second_velocity_i, LAT)))
    else $error("outcome does not match relative velocity");

  a_static_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && outcome_o != OUT_CONTACT) |-> (enter_time_o == '0 && leave_time_o == '0))
    else $error("times nonzero without contact");

  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && outcome_o == OUT_CONTACT) |-> (enter_time_o <= leave_time_o))
    else $error("contact ends before it begins");

endmodule

bind swept_interval_contact_times_unit sict_checker #(
  .COORD_BITS(COORD_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_sict_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .first_velocity_i (first_velocity_i),
  .second_velocity_i(second_velocity_i),
  .done_o           (done_o),
  .outcome_o        (outcome_o),
  .enter_time_o     (enter_time_o),
  .leave_time_o     (leave_time_o)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none

module tb_top import sict_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD       = DEF_COORD_BITS;
  localparam int FRAC        = DEF_FRAC_BITS;
  localparam int LATENCY     = COORD + FRAC + 4;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [COORD-1:0] C_MIN  = {1'b1, {(COORD-1){1'b0}}};
  localparam logic [COORD-1:0] C_MAX  = {1'b0, {(COORD-1){1'b1}}};
  localparam logic [COORD-1:0] C_ONE  = 1 << FRAC;
  localparam logic [COORD-1:0] C_MONE = -(1 << FRAC);
  localparam logic [COORD-2:0] W_MAX  = {(COORD-1){1'b1}};
  localparam logic [COORD-2:0] W_ONE  = (COORD-1)'(1 << FRAC);

  typedef struct {
    outcome_e                outcome;
    logic signed [COORD-1:0] enter_at;
    logic signed [COORD-1:0] leave_at;
  } contact_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic signed [COORD-1:0] first_start_i;
  logic        [COORD-2:0] first_width_i;
  logic signed [COORD-1:0] first_velocity_i;
  logic signed [COORD-1:0] second_start_i;
  logic        [COORD-2:0] second_width_i;
  logic signed [COORD-1:0] second_velocity_i;
  logic                    done_o;
  outcome_e                outcome_o;
  logic signed [COORD-1:0] enter_time_o;
  logic signed [COORD-1:0] leave_time_o;

  contact_result_t pending_contacts[$];
  contact_result_t oldest_contact;

  int error_count   = 0;
  int request_count = 0;
  int result_count  = 0;
  int cycle_count   = 0;
  int contact_count = 0;
  int never_count   = 0;
  int always_count  = 0;

  swept_interval_contact_times_unit #(
    .COORD_BITS(COORD),
    .FRAC_BITS (FRAC)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .first_start_i    (first_start_i),
    .first_width_i    (first_width_i),
    .first_velocity_i (first_velocity_i),
    .second_start_i   (second_start_i),
    .second_width_i   (second_width_i),
    .second_velocity_i(second_velocity_i),
    .done_o           (done_o),
    .outcome_o        (outcome_o),
    .enter_time_o     (enter_time_o),
    .leave_time_o     (leave_time_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // gap / relative velocity, truncated toward zero, saturated to the coordinate range
  function automatic logic [COORD-1:0] contact_quotient(input longint num, input longint den);
    bit        neg;
    bit [63:0] m, d, q, r, cap, lim;
    neg = (num < 0) != (den < 0);
    m   = (num < 0) ? 64'(-num) : 64'(num);
    d   = (den < 0) ? 64'(-den) : 64'(den);
    cap = 64'(1) << COORD;
    q   = m / d;
    r   = m % d;
    if (q > cap) q = cap;
    for (int i = 0; i < FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'(1);
      end
      if (q > cap) q = cap;
    end
    lim = 64'(1) << (COORD - 1);
    if (neg) begin
      if (q > lim) q = lim;
      return COORD'(64'(0) - q);
    end
    if (q > lim - 1) q = lim - 1;
    return COORD'(q);
  endfunction

  function automatic contact_result_t predict_contact(
    input logic [COORD-1:0] a, input logic [COORD-2:0] aw, input logic [COORD-1:0] av,
    input logic [COORD-1:0] b, input logic [COORD-2:0] bw, input logic [COORD-1:0] bv);
    contact_result_t res;
    longint sa, saw, sb, sbw, rel_v, near_gap, far_gap;
    sa       = longint'($signed(a));
    sb       = longint'($signed(b));
    saw      = longint'(aw);
    sbw      = longint'(bw);
    rel_v    = longint'($signed(av)) - longint'($signed(bv));
    near_gap = sb - (sa + saw);
    far_gap  = sb + sbw - sa;
    res.enter_at = '0;
    res.leave_at = '0;
    if (rel_v > 0) begin
      res.outcome  = OUT_CONTACT;
      res.enter_at = contact_quotient(near_gap, rel_v);
      res.leave_at = contact_quotient(far_gap, rel_v);
    end else if (rel_v < 0) begin
      res.outcome  = OUT_CONTACT;
      res.enter_at = contact_quotient(far_gap, rel_v);
      res.leave_at = contact_quotient(near_gap, rel_v);
    end else if ((sa + saw) < sb || sa > (sb + sbw)) begin
      res.outcome = OUT_NEVER;
    end else begin
      res.outcome = OUT_ALWAYS;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [COORD-1:0] got,
                                 input logic [COORD-1:0] want);
    $display("mismatch on result %0d: %s got %h want %h", result_count, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_contacts.size() == 0) begin
        report_mismatch("result with no request waiting", COORD'(outcome_o), '0);
      end else begin
        oldest_contact = pending_contacts.pop_front();
        if (outcome_o !== oldest_contact.outcome)
          report_mismatch("outcome", COORD'(outcome_o), COORD'(oldest_contact.outcome));
        if (enter_time_o !== oldest_contact.enter_at)
          report_mismatch("enter time", enter_time_o, oldest_contact.enter_at);
        if (leave_time_o !== oldest_contact.leave_at)
          report_mismatch("leave time", leave_time_o, oldest_contact.leave_at);
      end
      result_count++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_contacts.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_request(
    input logic [COORD-1:0] a, input logic [COORD-2:0] aw, input logic [COORD-1:0] av,
    input logic [COORD-1:0] b, input logic [COORD-2:0] bw, input logic [COORD-1:0] bv);
    contact_result_t res;
    start             <= 1'b1;
    first_start_i     <= a;
    first_width_i     <= aw;
    first_velocity_i  <= av;
    second_start_i    <= b;
    second_width_i    <= bw;
    second_velocity_i <= bv;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    res = predict_contact(a, aw, av, b, bw, bv);
    pending_contacts.push_back(res);
    request_count++;
    case (res.outcome)
      OUT_CONTACT: contact_count++;
      OUT_NEVER:   never_count++;
      default:     always_count++;
    endcase
  endtask

  // fields carry noise while start is low
  task automatic hold_off(input int cycles);
    start             <= 1'b0;
    first_start_i     <= COORD'($urandom);
    first_width_i     <= (COORD-1)'($urandom);
    first_velocity_i  <= COORD'($urandom);
    second_start_i    <= COORD'($urandom);
    second_width_i    <= (COORD-1)'($urandom);
    second_velocity_i <= COORD'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic maybe_hold_off();
    if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 5));
  endtask

  function automatic logic [COORD-1:0] pick_coord();
    logic [COORD-1:0] mag;
    case ($urandom_range(0, 4))
      0: return COORD'($urandom_range(0, 2047)) - COORD'(1024);
      1: return ($urandom_range(0, 1) ? C_MIN : C_MAX) ^ COORD'($urandom_range(0, 15));
      2: begin
        mag = COORD'($urandom) >> $urandom_range(0, COORD - 1);
        return $urandom_range(0, 1) ? -mag : mag;
      end
      default: return COORD'($urandom);
    endcase
  endfunction

  function automatic logic [COORD-2:0] pick_width();
    if ($urandom_range(0, 1) == 0) return (COORD-1)'($urandom);
    return (COORD-1)'($urandom) >> $urandom_range(0, COORD - 2);
  endfunction

  task automatic random_moving_request();
    logic [COORD-1:0] av;
    av = pick_coord();
    send_request(pick_coord(), pick_width(), av, pick_coord(), pick_width(),
                 ($urandom_range(0, 15) == 0) ? av : pick_coord());
  endtask

  task automatic test_directed();
    send_request('0, '0, '0, '0, '0, '0);
    send_request('0, W_ONE, C_ONE, 5 * C_ONE, W_ONE, '0);
    send_request(5 * C_ONE, W_ONE, C_MONE, '0, W_ONE, '0);
    // zero velocity, ends just touching, one lsb apart, one lsb past
    send_request('0, W_ONE, 7, C_ONE, '0, 7);
    send_request('0, W_ONE, 7, C_ONE + 1, '0, 7);
    send_request(3 * C_ONE, '0, '0, C_ONE, W_ONE << 1, '0);
    send_request(3 * C_ONE + 1, '0, '0, C_ONE, W_ONE << 1, '0);
    send_request(C_MAX, W_MAX, C_MAX, C_MIN, W_MAX, C_MAX);
    send_request(C_MIN, W_MAX, C_MIN, C_MIN, '0, C_MIN);
    send_request(C_MIN, W_MAX, '0, C_MAX, W_MAX, '0);
    // extreme relative velocities
    send_request(C_MIN, W_MAX, C_MAX, C_MAX, W_MAX, C_MIN);
    send_request(C_MAX, W_MAX, C_MIN, C_MIN, W_MAX, C_MAX);
    // one lsb of relative velocity drives both quotients into saturation
    send_request(C_MIN, '0, 1, C_MAX, '0, '0);
    send_request(C_MIN, '0, '1, C_MAX, '0, '0);
    send_request(C_MAX, W_MAX, 1, C_MIN, '0, '0);
    // fractional quotients truncate toward zero
    send_request('0, '0, 3, 1, '0, '0);
    send_request(1, '0, 3, '0, '0, '0);
    send_request('0, (COORD-1)'(5), '1, 7, (COORD-1)'(2), 2);
    // quotients at and just past the top of the range, and at its bottom
    send_request('0, '0, C_ONE, {1'b0, {(COORD-FRAC-1){1'b1}}, {FRAC{1'b0}}}, '0, '0);
    send_request('0, '0, C_ONE, C_MAX, '0, '0);
    send_request('0, '0, C_ONE >> 1, C_MAX - C_MAX / 2, '0, '0);
    send_request(C_MAX - C_MAX / 2, '0, C_ONE >> 1, '0, '0, '0);
  endtask

  task automatic test_static_overlap(input int count);
    logic [COORD-1:0] a, v;
    logic [COORD-2:0] aw, bw;
    for (int i = 0; i < count; i++) begin
      a  = pick_coord();
      v  = pick_coord();
      aw = ($urandom_range(0, 3) == 0) ? pick_width() : (COORD-1)'($urandom_range(0, 300));
      bw = ($urandom_range(0, 3) == 0) ? pick_width() : (COORD-1)'($urandom_range(0, 300));
      send_request(a, aw, v, a + COORD'($urandom_range(0, 800)) - COORD'(400), bw, v);
      maybe_hold_off();
    end
  endtask

  // relative velocity of a few lsbs pushes quotients toward saturation
  task automatic test_slow_closing(input int count);
    logic [COORD-1:0] av, dv;
    for (int i = 0; i < count; i++) begin
      av = COORD'($urandom);
      dv = COORD'($urandom_range(1, 16));
      send_request(pick_coord(), pick_width(), av, pick_coord(), pick_width(),
                   $urandom_range(0, 1) ? av + dv : av - dv);
      maybe_hold_off();
    end
  endtask

  task automatic test_moving_random(input int count);
    for (int i = 0; i < count; i++) begin
      random_moving_request();
      maybe_hold_off();
    end
  endtask

  task automatic test_back_to_back(input int count);
    for (int i = 0; i < count; i++) random_moving_request();
  endtask

  initial begin
    rst_ni            <= 1'b0;
    start             <= 1'b0;
    first_start_i     <= '0;
    first_width_i     <= '0;
    first_velocity_i  <= '0;
    second_start_i    <= '0;
    second_width_i    <= '0;
    second_velocity_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_static_overlap(400);
    test_slow_closing(200);
    test_moving_random(830);
    test_back_to_back(200);
    start <= 1'b0;

    while (pending_contacts.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("%0d requests, %0d results checked", request_count, result_count);
    $display("outcomes: %0d contact, %0d never, %0d always",
             contact_count, never_count, always_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
